// File: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point arithmetic unit.
// No dependencies; every other file depends on this package.
package fpa_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_SQRT = 3'd4
   } op_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] recip;
   } recip_rsp_type;

endpackage

// File: rtl/fpa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on fpa_pkg for the word and opcode widths.
interface fpa_req_if;
   logic                               valid;
   logic                               ready;
   logic [fpa_pkg::OP_W-1:0]           operation;
   logic signed [fpa_pkg::WORD_W-1:0]  operand_a;
   logic signed [fpa_pkg::WORD_W-1:0]  operand_b;

   modport source (output valid, operation, operand_a, operand_b, input ready);
   modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [fpa_pkg::WORD_W-1:0]  result;
   logic                               divide_by_zero;

   modport source (output valid, result, divide_by_zero, input ready);
   modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

// File: rtl/fixed_point_arith_unit.sv
`timescale 1ns / 1ps
// Q-format arithmetic unit: sequencer, output register and shared units.
// Depends on fpa_pkg, fpa_if, fpa_mul and fpa_recip.
//
// One word is in flight at a time; req_chan.ready stays low while it is
// worked on. Add, subtract, unused codes, a zero divisor and a square root
// of exactly one reach the output register the cycle after acceptance.
// Multiply passes through S_MUL and S_MUL_OUT and the single registered
// multiplier. Divide forms the reciprocal at one divider step per cycle,
// then uses the same multiplier. Square root spends a multiply state and a
// compare state on each result bit, FRAC_BITS bits below one and up to
// INT_BITS/2 + FRAC_BITS bits above one, plus an S_SQ_SEEK step for each
// position tested while locating the leading bit. A result waits in the
// output register and a new word is taken in the cycle that result leaves.
module fixed_point_arith_unit #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 16
) (
   input  logic   clock,
   input  logic   reset,
   fpa_req_if.sink   req_chan,
   fpa_rsp_if.source rsp_chan
);
   import fpa_pkg::*;

   localparam int          SQ_TOP = (INT_BITS >> 1) + FRAC_BITS - 1;
   localparam int          K_W    = $clog2(SQ_TOP + 1);
   localparam logic [WORD_W-1:0] ONE_WORD = WORD_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MUL,
      S_MUL_OUT,
      S_SQ_SEEK,
      S_SQ_MUL,
      S_SQ_CMP
   } state_type;

   state_type                state_ff, state_in;
   logic signed [WORD_W-1:0] a_ff, a_in;
   logic signed [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0]        root_ff, root_in;
   logic [K_W-1:0]           k_ff, k_in;
   logic                     neg_ff, neg_in;
   logic                     low_ff, low_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] result_ff, result_in;
   logic                     dz_ff, dz_in;

   logic                     in_ready;
   logic                     recip_start;
   logic [WORD_W-1:0]        a_mag, b_mag;
   logic [WORD_W-1:0]        trial;
   logic                     keep;
   logic signed [WORD_W-1:0] mul_a, mul_b;
   logic signed [WORD_W-1:0] prod;
   recip_rsp_type            recip_rsp;

   assign in_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign a_mag = req_chan.operand_a[WORD_W-1] ? WORD_W'(0) - req_chan.operand_a
                                                : req_chan.operand_a;
   assign b_mag = req_chan.operand_b[WORD_W-1] ? WORD_W'(0) - req_chan.operand_b
                                                : req_chan.operand_b;
   assign trial = root_ff ^ (WORD_W'(1) << k_ff);
   assign keep  = low_ff ? (prod >= a_ff) : (!prod[WORD_W-1] && (prod <= a_ff));
   assign mul_a = (state_ff == S_SQ_MUL) ? $signed(trial) : a_ff;
   assign mul_b = (state_ff == S_SQ_MUL) ? $signed(trial) : b_ff;

   fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock     (clock),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .prod_word (prod)
   );

   fpa_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
      .clock     (clock),
      .reset     (reset),
      .start     (recip_start),
      .divisor   (b_mag),
      .recip_rsp (recip_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      root_in      = root_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      low_in       = low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      result_in    = result_ff;
      dz_in        = dz_ff;
      recip_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && in_ready) begin
               a_in   = req_chan.operand_a;
               b_in   = req_chan.operand_b;
               neg_in = 1'b0;
               case (req_chan.operation)
                  OP_ADD: begin
                     result_in    = req_chan.operand_a + req_chan.operand_b;
                     dz_in        = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_SUB: begin
                     result_in    = req_chan.operand_a - req_chan.operand_b;
                     dz_in        = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_MUL: begin
                     state_in = S_MUL;
                  end
                  OP_DIV: begin
                     if (req_chan.operand_b == '0) begin
                        result_in    = '0;
                        dz_in        = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        a_in        = $signed(a_mag);
                        neg_in      = req_chan.operand_a[WORD_W-1] ^
                                      req_chan.operand_b[WORD_W-1];
                        recip_start = 1'b1;
                        state_in    = S_DIV;
                     end
                  end
                  OP_SQRT: begin
                     if (req_chan.operand_a == $signed(ONE_WORD)) begin
                        result_in    = $signed(ONE_WORD);
                        dz_in        = 1'b0;
                        rsp_valid_in = 1'b1;
                     end else if (req_chan.operand_a < $signed(ONE_WORD)) begin
                        low_in   = 1'b1;
                        root_in  = ONE_WORD - WORD_W'(1);
                        k_in     = K_W'(FRAC_BITS - 1);
                        state_in = S_SQ_MUL;
                     end else begin
                        low_in   = 1'b0;
                        root_in  = '0;
                        k_in     = K_W'(SQ_TOP);
                        state_in = S_SQ_SEEK;
                     end
                  end
                  default: begin
                     result_in    = '0;
                     dz_in        = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (recip_rsp.done) begin
               b_in     = $signed(recip_rsp.recip);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_MUL_OUT;
         end
         S_MUL_OUT: begin
            result_in    = neg_ff ? WORD_W'(0) - prod : prod;
            dz_in        = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SQ_SEEK: begin
            if ((WORD_W'(a_ff) >> k_ff) == '0) begin
               k_in = k_ff - 1'b1;
            end else begin
               state_in = S_SQ_MUL;
            end
         end
         S_SQ_MUL: begin
            state_in = S_SQ_CMP;
         end
         S_SQ_CMP: begin
            if (keep) begin
               root_in = trial;
            end
            if (k_ff == '0) begin
               result_in    = keep ? $signed(trial) : $signed(root_ff);
               dz_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_SQ_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      root_ff   <= root_in;
      k_ff      <= k_in;
      neg_ff    <= neg_in;
      low_ff    <= low_in;
      result_ff <= result_in;
      dz_ff     <= dz_in;
   end

   assign req_chan.ready          = in_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result         = result_ff;
   assign rsp_chan.divide_by_zero = dz_ff;

endmodule

// File: rtl/fpa_mul.sv
`timescale 1ns / 1ps
// Shared signed word multiplier with a registered fixed-point result.
// Depends on fpa_pkg for the word width.
module fpa_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic signed [fpa_pkg::WORD_W-1:0] mul_a,
   input  logic signed [fpa_pkg::WORD_W-1:0] mul_b,
   output logic signed [fpa_pkg::WORD_W-1:0] prod_word
);
   import fpa_pkg::*;

   logic signed [2*WORD_W-1:0] full_prod;
   logic signed [WORD_W-1:0]   prod_in;
   logic signed [WORD_W-1:0]   prod_ff;

   assign full_prod = mul_a * mul_b;
   assign prod_in   = $signed(full_prod[FRAC_BITS+WORD_W-1 -: WORD_W]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_word = prod_ff;

endmodule

// File: rtl/fpa_recip.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider forming floor((2^(2F)-1)/d)+1 modulo 2^32.
// Depends on fpa_pkg for the word width and the response struct.
module fpa_recip #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fpa_pkg::WORD_W-1:0]  divisor,
   output fpa_pkg::recip_rsp_type      recip_rsp
);
   import fpa_pkg::*;

   localparam int NUM_BITS = 2 * FRAC_BITS;
   localparam int CNT_W    = $clog2(NUM_BITS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] trial;
   logic              fits;

   assign trial = {rem_ff[WORD_W-2:0], 1'b1};
   assign fits  = trial >= div_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_BITS - 1);
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial - div_ff : trial;
         quo_in = {quo_ff[WORD_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign recip_rsp.done  = done_ff;
   assign recip_rsp.recip = quo_ff + WORD_W'(1);

endmodule
